// ===== rtl/scm_pkg.sv =====
package scm_pkg;

	// field widths of the request and result
	localparam int PIX_W      = 8;
	localparam int OUT_W      = 32;
	localparam int SIZE_FW    = 11;
	localparam int TAPS_FW    = 5;
	localparam int HALF_FW    = 4;
	localparam int SEL_FW     = 5;
	localparam int COEF_W     = 16;
	localparam int DIV_W      = 40;
	localparam int CFG_IDX_W  = 3;

	// datapath widths: row sums fit 30 bits, column sums 50 bits
	localparam int SAMP_W     = 30;
	localparam int ACC_W      = 50;

	// saturation limits on the quotient magnitude
	localparam logic [ACC_W-1:0] MAG_NEG_LIM = {{(ACC_W-OUT_W){1'b0}}, 32'h8000_0000};
	localparam logic [ACC_W-1:0] MAG_POS_LIM = {{(ACC_W-OUT_W){1'b0}}, 32'h7FFF_FFFF};
	localparam logic [OUT_W-1:0] SAT_NEG     = 32'h8000_0000;
	localparam logic [OUT_W-1:0] SAT_POS     = 32'h7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_TAP_COUNT    = 3'd2,
		REG_HALF_TAPS    = 3'd3,
		REG_NORM_DIVISOR = 3'd4,
		REG_COEF_SELECT  = 3'd5,
		REG_COEF_VALUE   = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_DRAIN,
		ST_COL,
		ST_DIV,
		ST_OUT,
		ST_FIN
	} seq_state_t;

	// tag that travels with each sample through the read and cell stages
	typedef struct packed {
		logic vld;
		logic last;
		logic col_ph;
	} tag_t;

endpackage

// ===== rtl/scm_cell.sv =====
module scm_cell import scm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     coef_we,
	input  logic signed [COEF_W-1:0] coef_wdata,
	input  logic                     tap_en,
	input  logic signed [SAMP_W-1:0] x,
	input  logic signed [ACC_W-1:0]  psum_in,
	output logic signed [ACC_W-1:0]  psum_out
);

	logic signed [COEF_W-1:0]        coef_q;
	logic signed [COEF_W-1:0]        coef_eff;
	logic signed [COEF_W+SAMP_W-1:0] prod;
	logic signed [ACC_W-1:0]         psum_q;

	// coefficient held by this tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_we) begin
			coef_q <= coef_wdata;
		end
	end

	// taps past the filter length count as zero
	always_comb begin
		if (tap_en) begin
			coef_eff = coef_q;
		end else begin
			coef_eff = '0;
		end
	end

	assign prod = coef_eff * x;

	// partial sum handed on to the next tap
	always_ff @(posedge clk) begin
		psum_q <= psum_in + ACC_W'(prod);
	end

	assign psum_out = psum_q;

endmodule

// ===== rtl/scm_div.sv =====
module scm_div import scm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [ACC_W-1:0] quotient
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] quo_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;
	logic             fits;

	// one restoring step: bring down the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q[DIV_W-1:0], quo_q[ACC_W-1]};
		trial   = shifted - {1'b0, dsr_q};
		fits    = !trial[DIV_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_W-2:0], fits};
			rem_q <= fits ? trial : shifted;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/separable_convolve_mirror.sv =====
// Separable 2D FIR on an 8-bit raster stream with mirrored borders. The block takes one request
// at a time. Every row sum that a pixel request completes streams 2*half_taps+1 samples from
// the row buffer through a chain of 2*MAX_HALF_TAPS+1 multiply-add taps, one sample per cycle,
// and the chain then empties. A pixel in the first h columns of a row has no row sum yet, and
// the last pixel of a row also streams the row sums of the last h columns. A pixel that also
// produces a result then streams the column sum through the same chain, waits for the divide
// (50 bit-serial divider steps) and loads the output register; the load waits only while a
// previous result still waits there. A drain request does the same when a tail is pending and
// nothing when none is. The first result appears half_taps rows plus half_taps pixels after its
// input position; drain requests flush the tail of the frame. The output register lets a
// finished result wait while the next request is taken. The user must see that configuration is
// written only while the block is idle; the block itself does not enforce it.
module separable_convolve_mirror import scm_pkg::*; #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HEIGHT    = 1024,
	parameter int MAX_HALF_TAPS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [OUT_W-1:0] gauss_value,
	output logic                 last_in_frame,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIV_W-1:0]     cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int SZW  = $clog2(MAX_WIDTH + 1);
	localparam int SZH  = $clog2(MAX_HEIGHT + 1);
	localparam int HTW  = $clog2(MAX_HALF_TAPS + 1);
	localparam int NC   = 2 * MAX_HALF_TAPS + 1;
	localparam int NCW  = $clog2(NC);
	localparam int SW   = NCW;
	localparam int MW0  = (SZW > SZH) ? SZW : SZH;
	localparam int MW   = (MW0 > HTW + 1) ? MW0 : HTW + 1;
	localparam int JW   = MW + 2;
	localparam int PW0  = (RW > HTW) ? RW : HTW;
	localparam int PW   = PW0 + SZW + 1;
	localparam int SUM_DEPTH = 2 ** (SW + CW);
	localparam logic signed [JW-1:0] ONE_J = JW'(1);

	// mirror an index into 0..n-1, edge not repeated below zero and repeated past the end
	function automatic logic signed [JW-1:0] reflect(input logic signed [JW-1:0] j,
			input logic signed [JW-1:0] n);
		logic signed [JW-1:0] r;
		r = j;
		if (r < 0) begin
			r = -r;
		end
		if (r >= n) begin
			r = (n <<< 1) - r - ONE_J;
		end
		if (r < 0) begin
			r = '0;
		end
		if (r >= n) begin
			r = n - ONE_J;
		end
		return r;
	endfunction

	// configuration registers
	logic [SIZE_FW-1:0] image_width_q;
	logic [SIZE_FW-1:0] image_height_q;
	logic [TAPS_FW-1:0] tap_count_q;
	logic [HALF_FW-1:0] half_taps_q;
	logic [DIV_W-1:0]   norm_q;
	logic [SEL_FW-1:0]  coef_sel_q;
	logic               cfg_we;

	// sequencer and counters
	seq_state_t         state_q, state_d;
	logic [CW-1:0]      in_col_q, out_col_q;
	logic [RW-1:0]      in_row_q, out_row_q;
	logic               tail_q;
	logic [CW-1:0]      cur_col_q, cs_q;
	logic               single_q, range_q;
	logic [SW-1:0]      slot_q;
	logic [NCW-1:0]     i_q;
	logic [PW-1:0]      p_q, lag_q;
	logic               frame_end_q;
	logic               neg_q;

	// derived sizes
	logic [SZW-1:0]     w_eff;
	logic [SZH-1:0]     hh_eff;
	logic [HTW-1:0]     h_eff;
	logic [NCW-1:0]     tap_idx;

	// accept-time decode
	logic               in_accept, pix_we;
	logic               col_wrap, row_wrap, frame_end;
	logic               single, range_job, has_jobs;
	logic [CW-1:0]      cs;

	// window walk
	logic               issue, i_last, row_done, fire, load;
	logic signed [JW-1:0] base_j, n_j, j_cur, refl;

	// read stages and chain
	tag_t               tag_s1, tag_s2;
	logic [CW-1:0]      col_s1, col_s2;
	logic [PIX_W-1:0]   pix_rd_q;
	logic [SAMP_W-1:0]  sum_rd_q;
	logic signed [SAMP_W-1:0] x;
	logic signed [ACC_W-1:0]  psum [NC];
	logic signed [ACC_W-1:0]  res_acc;
	logic               res_row, div_start, div_done;
	logic [ACC_W-1:0]   div_dividend, div_quo;
	logic [DIV_W-1:0]   div_divisor;

	// output register
	logic               out_valid_q, last_q, emit_last;
	logic [OUT_W-1:0]   gauss_q, gauss_d;

	logic [PIX_W-1:0]   win_mem [MAX_WIDTH];
	logic [SAMP_W-1:0]  sum_mem [SUM_DEPTH];

	// configuration writes
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_FW'(640);
			image_height_q <= SIZE_FW'(480);
			tap_count_q    <= TAPS_FW'(7);
			half_taps_q    <= HALF_FW'(3);
			norm_q         <= DIV_W'(1);
			coef_sel_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_FW-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_FW-1:0];
				REG_TAP_COUNT:    tap_count_q    <= cfg_data[TAPS_FW-1:0];
				REG_HALF_TAPS:    half_taps_q    <= cfg_data[HALF_FW-1:0];
				REG_NORM_DIVISOR: norm_q         <= cfg_data;
				REG_COEF_SELECT:  coef_sel_q     <= cfg_data[SEL_FW-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes, zero acts as one, clamp to the maximum
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = SZW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = SZW'(MAX_WIDTH);
		end else begin
			w_eff = SZW'(image_width_q);
		end
		if (image_height_q == '0) begin
			hh_eff = SZH'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			hh_eff = SZH'(MAX_HEIGHT);
		end else begin
			hh_eff = SZH'(image_height_q);
		end
		if (32'(half_taps_q) > MAX_HALF_TAPS) begin
			h_eff = HTW'(MAX_HALF_TAPS);
		end else begin
			h_eff = HTW'(half_taps_q);
		end
	end

	assign tap_idx = NCW'({h_eff, 1'b0});

	// request decode
	always_comb begin
		col_wrap  = (32'(in_col_q) + 32'd1 >= 32'(w_eff));
		row_wrap  = (32'(in_row_q) + 32'd1 >= 32'(hh_eff));
		frame_end = col_wrap && row_wrap;
		single    = (32'(in_col_q) >= 32'(h_eff));
		range_job = col_wrap && (h_eff != '0);
		has_jobs  = single || range_job;
		if (32'(w_eff) > 32'(h_eff)) begin
			cs = CW'(w_eff - SZW'(h_eff));
		end else begin
			cs = '0;
		end
	end

	// window index and its mirror
	always_comb begin
		if (state_q == ST_COL) begin
			base_j = JW'(out_row_q);
			n_j    = JW'(hh_eff);
		end else begin
			base_j = JW'(cur_col_q);
			n_j    = JW'(w_eff);
		end
		j_cur    = base_j - $signed(JW'(h_eff)) + $signed(JW'(i_q));
		refl     = reflect(j_cur, n_j);
		i_last   = (i_q == tap_idx);
		row_done = single_q ? !range_q : (32'(cur_col_q) + 32'd1 >= 32'(w_eff));
		fire     = (p_q >= lag_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_DRAIN) begin
						state_d = tail_q ? ST_COL : ST_IDLE;
					end else begin
						state_d = has_jobs ? ST_ROW : ST_DRAIN;
					end
				end
			end
			ST_ROW: begin
				if (i_last && row_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!tag_s1.vld && !tag_s2.vld) begin
					state_d = fire ? ST_COL : ST_FIN;
				end
			end
			ST_COL: begin
				if (i_last) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_ROW) || (state_q == ST_COL);
		load     = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	assign in_accept = in_valid && in_ready;
	assign pix_we    = in_accept && (opcode == OP_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters, job list and frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			tail_q      <= 1'b0;
			i_q         <= '0;
			single_q    <= 1'b0;
			range_q     <= 1'b0;
			frame_end_q <= 1'b0;
		end else begin
			if (in_accept) begin
				i_q <= '0;
				if (opcode == OP_DRAIN) begin
					frame_end_q <= 1'b0;
				end else begin
					if (tail_q) begin
						tail_q    <= 1'b0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					single_q    <= single;
					range_q     <= range_job;
					frame_end_q <= frame_end;
					if (frame_end || col_wrap) begin
						in_col_q <= '0;
						in_row_q <= frame_end ? '0 : in_row_q + 1'b1;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
			end
			if (issue) begin
				if (i_last) begin
					i_q <= '0;
					if (state_q == ST_ROW) begin
						single_q <= 1'b0;
					end
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (load) begin
				if (emit_last) begin
					out_col_q <= '0;
					out_row_q <= '0;
					tail_q    <= 1'b0;
				end else if (32'(out_col_q) + 32'd1 >= 32'(w_eff)) begin
					out_col_q <= '0;
					out_row_q <= (32'(out_row_q) + 32'd1 >= 32'(hh_eff)) ? '0 : out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
			if (state_q == ST_FIN && frame_end_q) begin
				tail_q <= (lag_q != '0);
			end
		end
	end

	// per-request payload: job columns, slot and position against lag
	always_ff @(posedge clk) begin
		if (pix_we) begin
			cur_col_q <= single ? in_col_q - CW'(h_eff) : cs;
			cs_q      <= cs;
			slot_q    <= SW'(in_row_q);
			p_q       <= PW'(in_row_q) * PW'(w_eff) + PW'(in_col_q);
			lag_q     <= PW'(h_eff) * PW'(w_eff) + PW'(h_eff);
		end else if (state_q == ST_ROW && i_last) begin
			cur_col_q <= single_q ? cs_q : cur_col_q + 1'b1;
		end
	end

	// row buffer
	always_ff @(posedge clk) begin
		if (pix_we) begin
			win_mem[in_col_q] <= pixel;
		end
		pix_rd_q <= win_mem[CW'(refl)];
	end

	// row sum store, slot from the low row bits
	always_ff @(posedge clk) begin
		if (res_row) begin
			sum_mem[{slot_q, col_s2}] <= res_acc[SAMP_W-1:0];
		end
		sum_rd_q <= sum_mem[{SW'(refl), out_col_q}];
	end

	// sample tags follow the memory read and the cell stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= '{vld: issue, last: i_last, col_ph: (state_q == ST_COL)};
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= cur_col_q;
		col_s2 <= col_s1;
	end

	assign x = tag_s1.col_ph ? sum_rd_q : {{(SAMP_W-PIX_W){1'b0}}, pix_rd_q};

	// chain of taps
	for (genvar k = 0; k < NC; k++) begin : g_cell
		logic signed [ACC_W-1:0] psum_in;
		if (k == 0) begin : g_head
			assign psum_in = '0;
		end else begin : g_link
			assign psum_in = psum[k-1];
		end
		scm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.coef_we    (cfg_we && (cfg_index == REG_COEF_VALUE) && (32'(coef_sel_q) == k)),
			.coef_wdata (cfg_data[COEF_W-1:0]),
			.tap_en     (32'(tap_count_q) > k),
			.x          (x),
			.psum_in    (psum_in),
			.psum_out   (psum[k])
		);
	end

	// window result from the tap at 2h
	assign res_acc   = psum[tap_idx];
	assign res_row   = tag_s2.vld && tag_s2.last && !tag_s2.col_ph;
	assign div_start = tag_s2.vld && tag_s2.last && tag_s2.col_ph;

	assign div_dividend = res_acc[ACC_W-1] ? ACC_W'(-res_acc) : ACC_W'(res_acc);
	assign div_divisor  = (norm_q == '0) ? DIV_W'(1) : norm_q;

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= res_acc[ACC_W-1];
		end
	end

	scm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturate and sign the quotient
	always_comb begin
		if (neg_q) begin
			gauss_d = (div_quo > MAG_NEG_LIM) ? SAT_NEG : OUT_W'(-div_quo);
		end else begin
			gauss_d = (div_quo > MAG_POS_LIM) ? SAT_POS : OUT_W'(div_quo);
		end
		emit_last = (32'(out_row_q) + 32'd1 >= 32'(hh_eff))
			&& (32'(out_col_q) + 32'd1 >= 32'(w_eff));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gauss_q <= gauss_d;
			last_q  <= emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign gauss_value   = gauss_q;
	assign last_in_frame = last_q;

`ifndef SYNTH
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!tag_s1.vld && !tag_s2.vld))
		else $error("request taken with samples still in flight");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide wait");

	a_start_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == ST_DIV))
		else $error("column sum arrived outside the divide wait");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (out_valid_q && state_q == ST_OUT))
		else $error("result overwritten while the previous one waits");
`endif

endmodule
